FILE: hw/rtl/lsab_pkg.sv
package lsab_pkg;

	// Bin store geometry
	localparam int MAX_BINS = 512;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int CNT_W    = $clog2(MAX_BINS + 1);

	// Field widths
	localparam int ANGLE_W   = 16;
	localparam int DIST_W    = 16;
	localparam int STR_W     = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Bin number: ceil(angle * (n - 1) / ANGLE_SPAN) through a reciprocal
	localparam int ANGLE_SPAN  = 36000;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP       = 1908874;   // floor(2^36 / 36000)
	localparam int X_W         = 26;        // angle * (n - 1) + span - 1
	localparam int Q_W         = 11;        // quotient estimate
	localparam int MA_W        = 26;
	localparam int MB_W        = 21;
	localparam int PROD_W      = MA_W + MB_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIN_COUNT = 3'd0,
		CFG_CROP_EN   = 3'd1,
		CFG_CROP_MIN  = 3'd2,
		CFG_CROP_MAX  = 3'd3,
		CFG_REVERSE   = 3'd4
	} cfg_idx_t;

	// One bin entry, valid flags kept with the data
	typedef struct packed {
		logic              range_ok;
		logic              strength_ok;
		logic [DIST_W-1:0] range;
		logic [STR_W-1:0]  strength;
	} bin_word_t;

	// Shared multiplier operations
	typedef enum logic [1:0] {
		MUL_SCALE = 2'd0,   // angle * (n - 1)
		MUL_RECIP = 2'd1,   // x * reciprocal of the span
		MUL_BACK  = 2'd2    // quotient estimate * span
	} mul_op_t;

	typedef struct packed {
		logic    en;
		mul_op_t op;
	} mul_req_t;

endpackage

FILE: hw/rtl/lsab_in_if.sv
interface lsab_in_if import lsab_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [ANGLE_W-1:0] angle_cdeg;
	logic [DIST_W-1:0]  distance;
	logic [STR_W-1:0]   strength;
	logic               rate_valid;

	modport source (
		output valid, mode, angle_cdeg, distance, strength, rate_valid,
		input  ready
	);
	modport sink (
		input  valid, mode, angle_cdeg, distance, strength, rate_valid,
		output ready
	);
endinterface

FILE: hw/rtl/lsab_out_if.sv
interface lsab_out_if import lsab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BIN_W-1:0]  bin_index;
	logic [DIST_W-1:0] bin_range;
	logic              range_ok;
	logic [STR_W-1:0]  bin_strength;
	logic              strength_ok;
	logic              publish;
	logic              last_bin;

	modport source (
		output valid, bin_index, bin_range, range_ok, bin_strength, strength_ok,
		       publish, last_bin,
		input  ready
	);
	modport sink (
		input  valid, bin_index, bin_range, range_ok, bin_strength, strength_ok,
		       publish, last_bin,
		output ready
	);
endinterface

FILE: hw/rtl/lsab_mul.sv
module lsab_mul import lsab_pkg::*; (
	input  logic               clk,
	input  mul_req_t           req,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [BIN_W-1:0]   n_m1,
	input  logic [X_W-1:0]     x,
	input  logic [Q_W-1:0]     q0,
	output logic [PROD_W-1:0]  prod_q
);

	logic [MA_W-1:0] op_a;
	logic [MB_W-1:0] op_b;

	// Operand select per operation
	always_comb begin
		case (req.op)
			MUL_SCALE: begin
				op_a = MA_W'(angle);
				op_b = MB_W'(n_m1);
			end
			MUL_RECIP: begin
				op_a = MA_W'(x);
				op_b = MB_W'(RECIP);
			end
			MUL_BACK: begin
				op_a = MA_W'(q0);
				op_b = MB_W'(ANGLE_SPAN);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Registered product
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

endmodule

FILE: hw/rtl/lidar_scan_angular_binning_core.sv
// Angular binning of lidar points, nearest valid range kept per bin.
// in_ch carries items: mode 0 accumulates one point (no result), mode 1
// drains the next bin (one result on out_ch). An item transfers when
// valid and ready are both high; ready is high only while the block idles.
// cfg_we/cfg_index/cfg_data write one configuration register per cycle.
// Accumulate: the shared multiplier runs three times (scale, reciprocal,
// back-multiply), then come correction, bin read and bin write through the
// bin memory with its one read and one write port. A point past a full
// turn is dropped after the correction step.
// Drain: the bin is read, then loaded into the output register and written
// back cleared once that register is free; the next item is taken only
// after that.
// After reset a clearing pass writes all 512 bin entries to zero; no
// item is taken meanwhile, configuration writes are taken as ever.
// Results sit in an output register: when the receiver stalls, a drain
// waits for the register to free up, accumulate points keep flowing.
module lidar_scan_angular_binning_core import lsab_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lsab_in_if.sink              in_ch,
	lsab_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_RECIP,
		ST_BACK,
		ST_CORR,
		ST_READ,
		ST_UPDATE,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [CNT_W-1:0]   bin_count_q;
	logic               crop_en_q;
	logic [ANGLE_W-1:0] crop_min_q;
	logic [ANGLE_W-1:0] crop_max_q;
	logic               reverse_q;

	// Scan state
	logic [BIN_W-1:0] drain_ptr_q;
	logic             first_scan_q;
	logic [BIN_W-1:0] clr_q;

	// Item registers
	logic [ANGLE_W-1:0] angle_q;
	logic [DIST_W-1:0]  dist_q;
	logic [STR_W-1:0]   str_q;
	logic               ok_q;
	logic [X_W-1:0]     x_q;
	logic [Q_W-1:0]     q0_q;
	logic [BIN_W-1:0]   bin_q;
	logic               last_q;
	logic               pub_q;

	// Bin memory
	bin_word_t        mem [MAX_BINS];
	bin_word_t        rd_q;
	logic             mem_we;
	logic [BIN_W-1:0] mem_waddr;
	bin_word_t        mem_wdata;
	logic             mem_re;
	logic [BIN_W-1:0] mem_raddr;

	// Output register
	logic              out_valid_q;
	logic [BIN_W-1:0]  out_index_q;
	logic [DIST_W-1:0] out_range_q;
	logic              out_range_ok_q;
	logic [STR_W-1:0]  out_str_q;
	logic              out_str_ok_q;
	logic              out_pub_q;
	logic              out_last_q;

	// Derived values
	logic [CNT_W-1:0]  n_act;
	logic [BIN_W-1:0]  n_m1;
	logic              accept;
	logic              in_ok;
	logic [BIN_W-1:0]  drain_p;
	logic [X_W-1:0]    x_next;
	logic [Q_W-1:0]    q0_next;
	logic [X_W-1:0]    rem;
	logic [Q_W-1:0]    bin_num;
	logic              out_free;
	logic              drain_load;
	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod_q;
	bin_word_t         upd_word;

	// Active bin count clamped to 2..MAX_BINS
	always_comb begin
		priority if (bin_count_q < CNT_W'(2)) begin
			n_act = CNT_W'(2);
		end else if (bin_count_q > CNT_W'(MAX_BINS)) begin
			n_act = CNT_W'(MAX_BINS);
		end else begin
			n_act = bin_count_q;
		end
	end
	assign n_m1 = BIN_W'(n_act - CNT_W'(1));

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	// Point validity: not a null return and not inside the crop window
	assign in_ok = !(in_ch.distance == '0 && in_ch.strength == '0) &&
		!(crop_en_q && in_ch.angle_cdeg >= crop_min_q &&
		  in_ch.angle_cdeg <= crop_max_q);

	// Drain pointer pinned to the final bin if the count shrank
	assign drain_p = ({1'b0, drain_ptr_q} >= n_act) ? n_m1 : drain_ptr_q;

	// Bin number steps around the shared multiplier
	assign x_next  = prod_q[X_W-1:0] + X_W'(ANGLE_SPAN - 1);
	assign q0_next = prod_q[RECIP_SHIFT +: Q_W];
	assign rem     = x_q - prod_q[X_W-1:0];
	assign bin_num = (rem >= X_W'(ANGLE_SPAN)) ? q0_q + Q_W'(1) : q0_q;

	always_comb begin
		mul_req.en = 1'b0;
		mul_req.op = MUL_SCALE;
		unique case (state_q)
			ST_SCALE: begin
				mul_req.en = 1'b1;
				mul_req.op = MUL_SCALE;
			end
			ST_RECIP: begin
				mul_req.en = 1'b1;
				mul_req.op = MUL_RECIP;
			end
			ST_BACK: begin
				mul_req.en = 1'b1;
				mul_req.op = MUL_BACK;
			end
			default: begin
			end
		endcase
	end

	lsab_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.angle  (angle_q),
		.n_m1   (n_m1),
		.x      (x_next),
		.q0     (q0_next),
		.prod_q (prod_q)
	);

	// Merge of a point into its bin
	always_comb begin
		upd_word.strength_ok = ok_q;
		upd_word.strength    = ok_q ? str_q : '0;
		if (!rd_q.range_ok) begin
			upd_word.range_ok = ok_q;
			upd_word.range    = ok_q ? dist_q : '0;
		end else begin
			upd_word.range_ok = 1'b1;
			upd_word.range    = (ok_q && dist_q < rd_q.range) ? dist_q : rd_q.range;
		end
	end

	assign out_free   = !out_valid_q || out_ch.ready;
	assign drain_load = (state_q == ST_DRAIN_OUT) && out_free;

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bin_q;
		mem_wdata = upd_word;
		mem_re    = 1'b0;
		mem_raddr = bin_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_UPDATE: begin
				mem_we = 1'b1;
			end
			ST_DRAIN_RD: begin
				mem_re = 1'b1;
			end
			ST_DRAIN_OUT: begin
				mem_we    = out_free;
				mem_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= CNT_W'(455);
			crop_en_q   <= 1'b0;
			crop_min_q  <= ANGLE_W'(9000);
			crop_max_q  <= ANGLE_W'(27000);
			reverse_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIN_COUNT: bin_count_q <= cfg_data[CNT_W-1:0];
				CFG_CROP_EN:   crop_en_q   <= cfg_data[0];
				CFG_CROP_MIN:  crop_min_q  <= cfg_data[ANGLE_W-1:0];
				CFG_CROP_MAX:  crop_max_q  <= cfg_data[ANGLE_W-1:0];
				CFG_REVERSE:   reverse_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			drain_ptr_q  <= '0;
			first_scan_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			// result taken and no new one loaded this cycle
			if (out_valid_q && out_ch.ready && !drain_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BIN_W'(1);
					if (clr_q == BIN_W'(MAX_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						angle_q <= in_ch.angle_cdeg;
						dist_q  <= in_ch.distance;
						str_q   <= in_ch.strength;
						ok_q    <= in_ok;
						bin_q   <= drain_p;
						last_q  <= (drain_p >= n_m1);
						pub_q   <= !first_scan_q && in_ch.rate_valid;
						state_q <= in_ch.mode ? ST_DRAIN_RD : ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_RECIP;
				ST_RECIP: begin
					x_q     <= x_next;
					state_q <= ST_BACK;
				end
				ST_BACK: begin
					q0_q    <= q0_next;
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					// bins past a full turn drop the point
					if (bin_num >= Q_W'(n_act)) begin
						state_q <= ST_IDLE;
					end else begin
						bin_q   <= reverse_q ? n_m1 - BIN_W'(bin_num) : BIN_W'(bin_num);
						state_q <= ST_READ;
					end
				end
				ST_READ:     state_q <= ST_UPDATE;
				ST_UPDATE:   state_q <= ST_IDLE;
				ST_DRAIN_RD: state_q <= ST_DRAIN_OUT;
				ST_DRAIN_OUT: begin
					if (drain_load) begin
						out_valid_q    <= 1'b1;
						out_index_q    <= bin_q;
						out_range_q    <= rd_q.range_ok ? rd_q.range : '0;
						out_range_ok_q <= rd_q.range_ok;
						out_str_q      <= rd_q.strength_ok ? rd_q.strength : '0;
						out_str_ok_q   <= rd_q.strength_ok;
						out_pub_q      <= pub_q;
						out_last_q     <= last_q;
						if (last_q) begin
							drain_ptr_q  <= '0;
							first_scan_q <= 1'b0;
						end else begin
							drain_ptr_q <= bin_q + BIN_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.bin_index    = out_index_q;
	assign out_ch.bin_range    = out_range_q;
	assign out_ch.range_ok     = out_range_ok_q;
	assign out_ch.bin_strength = out_str_q;
	assign out_ch.strength_ok  = out_str_ok_q;
	assign out_ch.publish      = out_pub_q;
	assign out_ch.last_bin     = out_last_q;

endmodule
